// File: rtl/frwa_pkg.sv
// Package for the frame-rate window average unit.
// Holds the window length, field widths and divider sizing; depends on nothing.
package frwa_pkg;

    localparam int WINDOW_LEN = 60;
    localparam int SLOT_W     = $clog2(WINDOW_LEN);
    localparam int SAMPLE_W   = 16;
    localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int TPS_W      = 16;
    localparam int FRAC_W     = 8;
    localparam int RATE_W     = TPS_W + FRAC_W;

    // Shared bit-serial divider: dividend width covers both divisions
    localparam int DIV_W      = (RATE_W > SUM_W) ? RATE_W : SUM_W;
    localparam int DSR_W      = SAMPLE_W;
    localparam int ITER_W     = $clog2(DIV_W);

    localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1000);

endpackage

// File: rtl/frame_rate_window_average_unit.sv
// Frame-rate window average unit: windowed mean frame time and Q8 rate.
// Mean and rate come from two 24-step bit-serial restoring divisions sharing one
// subtractor; an empty window skips both and a zero mean skips the rate division.
// New items stall until the current one reaches the result register, which lets
// the next item enter while a result waits. Async active-low reset clears the
// slot valid bits at once (no clearing pass) and sets ticks_per_second to 1000.
// Depends on frwa_pkg.
module frame_rate_window_average_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [frwa_pkg::SAMPLE_W-1:0]   frame_time,
    // configuration channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [frwa_pkg::TPS_W-1:0]      ticks_per_second,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [frwa_pkg::SAMPLE_W-1:0]   mean_frame_time,
    output logic [frwa_pkg::RATE_W-1:0]     rate_q8,
    output logic                            no_samples
);
    import frwa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV_MEAN,
        ST_DIV_RATE,
        ST_DONE
    } state_t;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DIV_W - 1);

    state_t                 state_reg, state_next;
    logic [TPS_W-1:0]       tps_reg, tps_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [WINDOW_LEN-1:0]  valid_reg, valid_next;
    logic [SAMPLE_W-1:0]    fresh_reg, fresh_next;
    logic                   old_valid_reg, old_valid_next;
    logic [SAMPLE_W-1:0]    rd_data_reg;
    logic                   empty_reg, empty_next;
    logic [SAMPLE_W-1:0]    mean_reg, mean_next;
    logic [DIV_W-1:0]       dvd_reg, dvd_next;
    logic [DSR_W-1:0]       dsr_reg, dsr_next;
    logic [DSR_W-1:0]       rem_reg, rem_next;
    logic [ITER_W-1:0]      iter_reg, iter_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]    out_mean_reg, out_mean_next;
    logic [RATE_W-1:0]      out_rate_reg, out_rate_next;
    logic                   out_empty_reg, out_empty_next;

    logic [SAMPLE_W-1:0] sample_mem [WINDOW_LEN];

    logic                in_xfer;
    logic                out_free;
    logic                mem_we;
    logic [SAMPLE_W-1:0] old_sample;
    logic [SUM_W-1:0]    upd_sum;
    logic [CNT_W-1:0]    upd_count;
    logic [DSR_W:0]      rem_shift;
    logic                rem_ge;
    logic [DSR_W:0]      rem_diff;
    logic [DIV_W-1:0]    step_dvd;
    logic [DSR_W-1:0]    step_rem;
    logic [SAMPLE_W-1:0] step_mean;

    assign in_stall        = (state_reg != ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign mean_frame_time = out_mean_reg;
    assign rate_q8         = out_rate_reg;
    assign no_samples      = out_empty_reg;

    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign mem_we   = (state_reg == ST_UPDATE);

    // Replace the oldest slot in the running sum and count
    assign old_sample = old_valid_reg ? rd_data_reg : '0;
    assign upd_sum    = sum_reg - SUM_W'(old_sample) + SUM_W'(fresh_reg);
    assign upd_count  = count_reg - CNT_W'(old_sample != '0) + CNT_W'(fresh_reg != '0);

    // One restoring division step: shift in a dividend bit, try the subtract
    assign rem_shift = {rem_reg, dvd_reg[DIV_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};
    assign rem_ge    = (rem_shift >= {1'b0, dsr_reg});
    assign step_rem  = rem_ge ? rem_diff[DSR_W-1:0] : rem_shift[DSR_W-1:0];
    assign step_dvd  = {dvd_reg[DIV_W-2:0], rem_ge};
    assign step_mean = step_dvd[SAMPLE_W-1:0];

    // Next-state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        tps_next       = tps_reg;
        slot_next      = slot_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        valid_next     = valid_reg;
        fresh_next     = fresh_reg;
        old_valid_next = old_valid_reg;
        empty_next     = empty_reg;
        mean_next      = mean_reg;
        dvd_next       = dvd_reg;
        dsr_next       = dsr_reg;
        rem_next       = rem_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg;
        out_mean_next  = out_mean_reg;
        out_rate_next  = out_rate_reg;
        out_empty_next = out_empty_reg;

        // Take a register write
        if (cfg_valid && cfg_ready)
        begin
            tps_next = ticks_per_second;
        end

        // Drop the result once its transfer completes
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    fresh_next     = frame_time;
                    old_valid_next = valid_reg[slot_reg];
                    state_next     = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                sum_next             = upd_sum;
                count_next           = upd_count;
                valid_next[slot_reg] = 1'b1;
                slot_next            = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                rem_next             = '0;
                iter_next            = '0;
                if (upd_count == '0)
                begin
                    empty_next = 1'b1;
                    mean_next  = '0;
                    dvd_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    empty_next = 1'b0;
                    dvd_next   = DIV_W'(upd_sum);
                    dsr_next   = DSR_W'(upd_count);
                    state_next = ST_DIV_MEAN;
                end
            end
            ST_DIV_MEAN:
            begin
                dvd_next  = step_dvd;
                rem_next  = step_rem;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_LAST)
                begin
                    mean_next = step_mean;
                    rem_next  = '0;
                    iter_next = '0;
                    if (step_mean == '0)
                    begin
                        dvd_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        dvd_next   = DIV_W'({tps_reg, {FRAC_W{1'b0}}});
                        dsr_next   = step_mean;
                        state_next = ST_DIV_RATE;
                    end
                end
            end
            ST_DIV_RATE:
            begin
                dvd_next  = step_dvd;
                rem_next  = step_rem;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold until the result register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_mean_next  = mean_reg;
                    out_rate_next  = dvd_reg[RATE_W-1:0];
                    out_empty_next = empty_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tps_reg       <= TPS_RESET;
            slot_reg      <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            valid_reg     <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tps_reg       <= tps_next;
            slot_reg      <= slot_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            valid_reg     <= valid_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        fresh_reg     <= fresh_next;
        old_valid_reg <= old_valid_next;
        empty_reg     <= empty_next;
        mean_reg      <= mean_next;
        dvd_reg       <= dvd_next;
        dsr_reg       <= dsr_next;
        rem_reg       <= rem_next;
        out_mean_reg  <= out_mean_next;
        out_rate_reg  <= out_rate_next;
        out_empty_reg <= out_empty_next;
    end

    // Sample ring: read the oldest slot on transfer, write the fresh sample on update
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_mem[slot_reg] <= fresh_reg;
        end
        if (in_xfer)
        begin
            rd_data_reg <= sample_mem[slot_reg];
        end
    end

endmodule

// File: verif/frame_rate_window_average_unit_tb.sv
// Testbench for the frame-rate window average unit: random and directed frame times
// against a cycle-free shadow of the 60-slot window, checked field by field.
// Depends on frwa_pkg and frame_rate_window_average_unit.
module frame_rate_window_average_unit_tb;

    import frwa_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 120;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mean;
        logic [RATE_W-1:0]   rate;
        logic                empty;
    } avg_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [SAMPLE_W-1:0] frame_time = '0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [TPS_W-1:0]    ticks_per_second = TPS_RESET;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [SAMPLE_W-1:0] mean_frame_time;
    logic [RATE_W-1:0]   rate_q8;
    logic                no_samples;

    // Shadow of the block's window state and rate register
    logic [SAMPLE_W-1:0] ring_shadow [WINDOW_LEN];
    logic [SLOT_W-1:0]   slot_shadow;
    logic [SUM_W-1:0]    sum_shadow;
    logic [CNT_W-1:0]    count_shadow;
    logic [TPS_W-1:0]    tps_shadow;

    logic [SAMPLE_W-1:0] frame_backlog [$];
    avg_result_t         expected_avg_q [$];

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned hold_req = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    frame_rate_window_average_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .frame_time       (frame_time),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .ticks_per_second (ticks_per_second),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .mean_frame_time  (mean_frame_time),
        .rate_q8          (rate_q8),
        .no_samples       (no_samples)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Advance the window shadow by one frame and queue the expected average
    task automatic predict_window_average(input logic [SAMPLE_W-1:0] fresh);
        logic [SAMPLE_W-1:0] evicted;
        avg_result_t         res;
        evicted = ring_shadow[slot_shadow];
        sum_shadow = sum_shadow - SUM_W'(evicted) + SUM_W'(fresh);
        if (evicted != 0)
            count_shadow = count_shadow - 1'b1;
        if (fresh != 0)
            count_shadow = count_shadow + 1'b1;
        ring_shadow[slot_shadow] = fresh;
        slot_shadow = (slot_shadow == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_shadow + 1'b1;
        res = '0;
        res.empty = 1'b1;
        if (count_shadow != 0)
        begin
            res.empty = 1'b0;
            res.mean = SAMPLE_W'(sum_shadow / count_shadow);
            if (res.mean != 0)
                res.rate = RATE_W'({tps_shadow, FRAC_W'(0)} / res.mean);
        end
        expected_avg_q.push_back(res);
    endtask

    // Frame durations: mostly typical frame times, plus zeros, extremes and full range
    function automatic logic [SAMPLE_W-1:0] pick_frame();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 12)
            return '0;
        else if (roll < 27)
            return SAMPLE_W'($urandom_range(65535, 0));
        else if (roll < 37)
            return SAMPLE_W'($urandom_range(65535, 65000));
        else if (roll < 45)
            return SAMPLE_W'($urandom_range(3, 1));
        else
            return SAMPLE_W'($urandom_range(50, 8));
    endfunction

    // Queue random frames; optionally splice in a zero run that empties the window
    task automatic queue_frames(input int unsigned count, input bit zero_run);
        for (int unsigned i = 0; i < count; i++)
        begin
            if (zero_run && i == count / 2)
                for (int k = 0; k <= WINDOW_LEN; k++)
                    frame_backlog.push_back('0);
            frame_backlog.push_back(pick_frame());
        end
    endtask

    // Wait until every queued frame is sent and every average has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (frame_backlog.size() != 0 || in_valid || expected_avg_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Write the rate register while the block is idle
    task automatic write_ticks(input logic [TPS_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        ticks_per_second <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tps_shadow = value;
        @(negedge clk);
    endtask

    // Main sequence: reset, directed frames, then random phases at several rates
    initial
    begin
        logic [SAMPLE_W-1:0] directed [];
        directed = '{
            16'd0, 16'd0, 16'd1, 16'd65535, 16'd65535, 16'd1, 16'd0, 16'd16,
            16'd17, 16'd33, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'd32768,
            16'd1, 16'd0, 16'd65535, 16'd2, 16'd1000
        };
        for (int k = 0; k < WINDOW_LEN; k++)
            ring_shadow[k] = '0;
        slot_shadow = '0;
        sum_shadow = '0;
        count_shadow = '0;
        tps_shadow = TPS_RESET;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames at the reset rate value; empty window first
        tx_idle_pct = 17;
        rx_idle_pct = 61;
        foreach (directed[i])
            frame_backlog.push_back(directed[i]);
        wait_drained();

        // Largest rate register; long receiver hold while the sender keeps offering
        write_ticks(16'hFFFF);
        queue_frames(150, 1'b0);
        hold_req++;
        wait_drained();

        // Smallest nonzero rate register, idling swapped, window emptied midway
        tx_idle_pct = 61;
        rx_idle_pct = 17;
        write_ticks(16'd1);
        queue_frames(150, 1'b1);
        wait_drained();

        // Zero rate register
        write_ticks('0);
        queue_frames(80, 1'b0);
        wait_drained();

        // No idling, random rate register
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_ticks(TPS_W'($urandom_range(65535, 0)));
        queue_frames(200, 1'b0);
        wait_drained();

        // Back to milliseconds, another long hold
        write_ticks(TPS_W'(1000));
        queue_frames(100, 1'b1);
        hold_req++;
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_avg_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Frame driver: hold the offered frame until it transfers, then offer the next
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_window_average(frame_time);
            if (!in_valid || !in_stall)
            begin
                if (frame_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    in_valid <= 1'b1;
                    frame_time <= frame_backlog.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result stall: random idling, or a long hold counted down here
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_seen)
        begin
            out_stall <= 1'b1;
            hold_left <= LONG_HOLD;
            hold_seen <= hold_req;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Result monitor: compare each transfer with the oldest expected average
    always @(posedge clk)
    begin
        avg_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_avg_q.size() == 0)
            begin
                $error("unexpected result: mean_frame_time %0d rate_q8 %0d no_samples %0b",
                       mean_frame_time, rate_q8, no_samples);
                mismatches++;
            end
            else
            begin
                want = expected_avg_q.pop_front();
                if (mean_frame_time !== want.mean)
                begin
                    $error("mean_frame_time: expected %0d, actual %0d",
                           want.mean, mean_frame_time);
                    mismatches++;
                end
                if (rate_q8 !== want.rate)
                begin
                    $error("rate_q8: expected %0d, actual %0d", want.rate, rate_q8);
                    mismatches++;
                end
                if (no_samples !== want.empty)
                begin
                    $error("no_samples: expected %0b, actual %0b", want.empty, no_samples);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
